// ===== sv/mcp_pkg.sv =====
package mcp_pkg;

    // Register indexes, decoded from the word address.
    localparam logic REG_OPEN  = 1'b0;
    localparam logic REG_CLOSE = 1'b1;

    localparam logic [7:0] OPEN_RESET  = 8'd60;
    localparam logic [7:0] CLOSE_RESET = 8'd62;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Magnitude limit of a token; one above the largest positive value.
    localparam logic [15:0] ACC_SAT = 16'd32768;

    localparam int FIELDS = 4;
    localparam logic [2:0] FIELD_RUN   = 3'd0;
    localparam logic [2:0] FIELD_DUTY  = 3'd1;
    localparam logic [2:0] FIELD_DIR   = 3'd2;
    localparam logic [2:0] FIELD_DEMO  = 3'd3;
    localparam logic [2:0] FIELD_COUNT = 3'd4;

    // The four fields, kept only as the facts the outputs need.
    typedef struct packed {
        logic       run_nz;
        logic [7:0] duty;
        logic       dir_zero;
        logic       demo_one;
    } summ_t;

    localparam summ_t SUMM_RESET = '{run_nz: 1'b0, duty: 8'd0, dir_zero: 1'b1, demo_one: 1'b0};

    typedef struct packed {
        logic  done;
        summ_t fields;
    } cmd_t;

endpackage

// ===== sv/mcp_front.sv =====
module mcp_front #(
    parameter int BUFFER_CHARS = 31
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic [7:0]     open_marker,
    input  logic [7:0]     close_marker,
    input  logic           q_full,
    output logic           q_push,
    output mcp_pkg::cmd_t  q_cmd
);

    localparam int CW = $clog2(BUFFER_CHARS + 1);
    localparam logic [CW-1:0] LIMIT = CW'(BUFFER_CHARS);

    typedef enum logic [1:0] {PH_WAIT, PH_BLANK, PH_DIGIT, PH_DONE} phase_t;

    logic                  in_frame_reg, in_frame_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [2:0]            fnum_reg, fnum_next;
    phase_t                phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [15:0]           acc_reg, acc_next;
    mcp_pkg::summ_t        pend_reg, pend_next;

    mcp_pkg::summ_t        pend_fin;
    logic [2:0]            fnum_fin;
    logic [7:0]            clamp;
    logic                  is_close, is_open, is_digit, is_blank;
    phase_t                p0;
    logic                  neg0;
    logic [15:0]           acc0, acc_dig;
    logic [19:0]           mul;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    assign is_close = (in_byte == close_marker) && in_frame_reg;
    assign is_open  = (in_byte == open_marker);
    assign is_digit = (in_byte >= mcp_pkg::CHAR_ZERO) && (in_byte <= mcp_pkg::CHAR_NINE);
    assign is_blank = (in_byte == mcp_pkg::CHAR_SPACE) ||
                      ((in_byte >= mcp_pkg::CHAR_TAB) && (in_byte <= mcp_pkg::CHAR_CR));

    // Closing the current token: a negative value clamps to zero duty.
    always_comb
    begin
        if (neg_reg)
            clamp = 8'd0;
        else if (acc_reg > 16'd255)
            clamp = 8'hFF;
        else
            clamp = acc_reg[7:0];

        pend_fin = pend_reg;
        fnum_fin = fnum_reg;
        if (phase_reg != PH_WAIT)
        begin
            case (fnum_reg)
                mcp_pkg::FIELD_RUN:  pend_fin.run_nz   = (acc_reg != 16'd0);
                mcp_pkg::FIELD_DUTY: pend_fin.duty     = clamp;
                mcp_pkg::FIELD_DIR:  pend_fin.dir_zero = (acc_reg == 16'd0);
                mcp_pkg::FIELD_DEMO: pend_fin.demo_one = !neg_reg && (acc_reg == 16'd1);
                default: ;
            endcase
            if (fnum_reg < mcp_pkg::FIELD_COUNT)
                fnum_fin = fnum_reg + 3'd1;
        end
    end

    assign q_cmd.done   = is_close;
    assign q_cmd.fields = pend_fin;

    // A token that has not started yet behaves as if it had just started.
    assign p0   = (phase_reg == PH_WAIT) ? PH_BLANK : phase_reg;
    assign neg0 = (phase_reg == PH_WAIT) ? 1'b0 : neg_reg;
    assign acc0 = (phase_reg == PH_WAIT) ? 16'd0 : acc_reg;

    always_comb
    begin
        mul = {1'b0, acc0, 3'b000} + {3'b000, acc0, 1'b0} + {12'd0, in_byte - mcp_pkg::CHAR_ZERO};
        if (mul > {4'd0, mcp_pkg::ACC_SAT})
            acc_dig = mcp_pkg::ACC_SAT;
        else
            acc_dig = mul[15:0];
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        fnum_next     = fnum_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        pend_next     = pend_reg;

        if (q_push)
        begin
            if (is_close)
            begin
                in_frame_next = 1'b0;
                phase_next    = PH_WAIT;
                fnum_next     = fnum_fin;
                pend_next     = pend_fin;
            end
            if (is_open)
            begin
                in_frame_next = 1'b1;
                count_next    = '0;
                fnum_next     = 3'd0;
                phase_next    = PH_WAIT;
                neg_next      = 1'b0;
                acc_next      = 16'd0;
                pend_next     = mcp_pkg::SUMM_RESET;
            end
            else if (in_frame_reg && !is_close && (count_reg < LIMIT))
            begin
                if (in_byte == mcp_pkg::CHAR_NUL)
                begin
                    // A zero byte ends the usable text of the frame.
                    count_next = LIMIT;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    if (in_byte == mcp_pkg::CHAR_COMMA)
                    begin
                        phase_next = PH_WAIT;
                        fnum_next  = fnum_fin;
                        pend_next  = pend_fin;
                    end
                    else
                    begin
                        phase_next = p0;
                        neg_next   = neg0;
                        acc_next   = acc0;
                        unique case (p0)
                            PH_BLANK:
                            begin
                                if (is_blank)
                                    phase_next = PH_BLANK;
                                else if ((in_byte == mcp_pkg::CHAR_PLUS) ||
                                         (in_byte == mcp_pkg::CHAR_MINUS))
                                begin
                                    neg_next   = (in_byte == mcp_pkg::CHAR_MINUS);
                                    phase_next = PH_DIGIT;
                                end
                                else if (is_digit)
                                begin
                                    acc_next   = acc_dig;
                                    phase_next = PH_DIGIT;
                                end
                                else
                                    phase_next = PH_DONE;
                            end
                            PH_DIGIT:
                            begin
                                if (is_digit)
                                    acc_next = acc_dig;
                                else
                                    phase_next = PH_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            fnum_reg     <= 3'd0;
            phase_reg    <= PH_WAIT;
            neg_reg      <= 1'b0;
            acc_reg      <= 16'd0;
            pend_reg     <= mcp_pkg::SUMM_RESET;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            fnum_reg     <= fnum_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            acc_reg      <= acc_next;
            pend_reg     <= pend_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT)
        else $error("character count ran past the buffer limit");

    a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fnum_reg <= mcp_pkg::FIELD_COUNT)
        else $error("field number ran past the last field");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= mcp_pkg::ACC_SAT)
        else $error("token magnitude escaped saturation");
`endif

endmodule

// ===== sv/mcp_queue.sv =====
module mcp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mcp_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output mcp_pkg::cmd_t  pop_cmd
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    mcp_pkg::cmd_t   entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg, count_next;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && valid))
            count_next = count_reg + 1'b1;
        else if (!push && pop && valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request written into a full queue");
`endif

endmodule

// ===== sv/mcp_back.sv =====
module mcp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mcp_pkg::cmd_t  q_cmd,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           brake_on,
    output logic           direction_level,
    output logic [7:0]     pwm_duty,
    output logic           demo_request,
    output logic           frame_done
);

    logic           out_valid_reg, out_valid_next;
    mcp_pkg::summ_t summ_reg, summ_next;
    logic [7:0]     held_reg, held_next;
    logic           brake_reg, dir_reg, demo_reg, done_reg;
    logic [7:0]     duty_reg;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        summ_next      = summ_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (q_pop)
        begin
            if (q_cmd.done)
                summ_next = q_cmd.fields;
            // The duty follows the committed value only while running.
            if (summ_next.run_nz)
                held_next = summ_next.duty;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            summ_reg      <= mcp_pkg::SUMM_RESET;
            held_reg      <= 8'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            summ_reg      <= summ_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            brake_reg <= !summ_next.run_nz;
            dir_reg   <= summ_next.dir_zero;
            duty_reg  <= held_next;
            demo_reg  <= summ_next.demo_one;
            done_reg  <= q_cmd.done;
        end
    end

    assign out_valid       = out_valid_reg;
    assign brake_on        = brake_reg;
    assign direction_level = dir_reg;
    assign pwm_duty        = duty_reg;
    assign demo_request    = demo_reg;
    assign frame_done      = done_reg;

`ifndef SYNTHESIS
    a_held_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        summ_reg.run_nz |-> (held_reg == summ_reg.duty))
        else $error("held duty differs from committed duty while running");
`endif

endmodule

// ===== sv/framed_motor_command_parser.sv =====
// A byte accepted at the input is written into the queue, from which it is popped
// into the output register that drives the result port. Throughput: one byte per
// cycle while the queue is not full; the output register and a two-entry queue
// between parser and output stage let either side stall without losing a beat.
// Reset (rst_n low, asynchronous) leaves the parser outside a frame, the committed
// fields at zero, the held duty at zero and the markers at '<' and '>'.
module framed_motor_command_parser #(
    parameter int BUFFER_CHARS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] brake_on, [1] direction_level, [9:2] pwm_duty,
                                    // [10] demo_request, [15:11] zero
    output logic        m_tlast,    // frame_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]    open_reg, close_reg;
    logic          q_full, q_push, q_valid, q_pop;
    mcp_pkg::cmd_t push_cmd, pop_cmd;
    logic          brake_on, direction_level, demo_request;
    logic [7:0]    pwm_duty;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= mcp_pkg::OPEN_RESET;
            close_reg <= mcp_pkg::CLOSE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                mcp_pkg::REG_OPEN:  open_reg  <= pwdata[7:0];
                mcp_pkg::REG_CLOSE: close_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mcp_pkg::REG_OPEN:  prdata = {24'd0, open_reg};
            mcp_pkg::REG_CLOSE: prdata = {24'd0, close_reg};
            default:            prdata = 32'd0;
        endcase
    end

    mcp_front #(
        .BUFFER_CHARS (BUFFER_CHARS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .open_marker  (open_reg),
        .close_marker (close_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    mcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    mcp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (pop_cmd),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .brake_on        (brake_on),
        .direction_level (direction_level),
        .pwm_duty        (pwm_duty),
        .demo_request    (demo_request),
        .frame_done      (m_tlast)
    );

    assign m_tdata = {5'd0, demo_request, pwm_duty, direction_level, brake_on};

endmodule
